@@ rtl/core/spp_pkg.sv @@
// shared types, register codes and saturation helper for the smith predictor pi controller
// no dependencies
`default_nettype none

package spp_pkg;

    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_KP         = 3'd1,
        REG_KI_DT      = 3'd2,
        REG_DECAY      = 3'd3,
        REG_INPUT_GAIN = 3'd4,
        REG_DELAY      = 3'd5
    } spp_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MDEC,
        ST_MGAIN,
        ST_MODEL,
        ST_FB,
        ST_ERR,
        ST_KI,
        ST_INT,
        ST_DRV
    } spp_state_t;

    typedef enum logic [1:0] {
        OP_DECAY,
        OP_GAIN,
        OP_KI,
        OP_KP
    } spp_op_t;

    typedef struct packed {
        logic write;
    } spp_hist_ctl_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } spp_sat_t;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    function automatic spp_sat_t sat32(input logic signed [ACC_W-1:0] v);
        spp_sat_t r;
        if (v > SAT_MAX) begin
            r.value = 32'sh7FFF_FFFF;
            r.clip  = 1'b1;
        end else if (v < SAT_MIN) begin
            r.value = -32'sh8000_0000;
            r.clip  = 1'b1;
        end else begin
            r.value = v[31:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/smith_predictor_pi_controller.sv @@
// smith predictor pi controller: top level with sequencer, config registers and datapath
// uses spp_pkg, spp_mul, spp_hist
//
// usage
//   s_ channel: one item per control tick, the measured plant output (signed q16.16)
//   m_ channel: one item per tick with the new drive, the delay-free predicted
//   feedback and a flag set when any sum clipped to the 32-bit range
//   cfg channel: register writes, always ready; write only while the block is idle
//   (no item in flight); register order: setpoint, kp, ki*dt, model decay,
//   model input gain, model delay
// timing
//   one shared 32x32 multiplier steps through four products under a nine-state
//   sequencer; the result is loaded into the output register in its last step
//   s_ready is high only in idle, so no new item is taken until the last one is done
// reset
//   aresetn is synchronous; model, integrator, previous drive and history
//   pointer clear; the history reads as zero until written (tracked by a wrap
//   flag, no clearing pass), config returns to its reset values
// stall
//   a result waits in the output register; if the previous result is still
//   held when the next one is ready, the sequencer waits in its last step
`default_nettype none

module smith_predictor_pi_controller #(
    parameter int DELAY_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_measured,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_drive,
    output logic signed [31:0]              m_predicted_feedback,
    output logic                            m_saturated,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import spp_pkg::*;

    // configuration registers
    logic signed [31:0] setpoint_reg;
    logic [30:0]        kp_reg;
    logic [30:0]        ki_reg;
    logic [16:0]        decay_reg;
    logic signed [31:0] gain_reg;
    logic [7:0]         delay_reg;

    // sequencer
    spp_state_t state_reg;
    spp_state_t state_next;

    // controller state
    logic signed [31:0] ym_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] prev_reg;

    // per-item working registers
    logic signed [31:0]      meas_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      fb_reg;
    logic signed [31:0]      err_reg;
    logic                    flag_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_drive_reg;
    logic signed [31:0] m_fb_reg;
    logic               m_sat_reg;

    // sequencer outputs
    spp_op_t       op_sel;
    spp_hist_ctl_t hist_ctl;
    logic          ld_acc;
    logic          ld_model;
    logic          ld_fb;
    logic          ld_err;
    logic          ld_int;
    logic          ld_out;

    logic                    accept;
    logic                    out_free;
    logic signed [31:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [ACC_W-1:0] mul_q;
    logic signed [31:0]      delayed;

    spp_sat_t model_sat;
    spp_sat_t fb_sat;
    spp_sat_t err_sat;
    spp_sat_t int_sat;
    spp_sat_t drv_sat;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // config write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            kp_reg       <= 31'd65536;
            ki_reg       <= '0;
            decay_reg    <= '0;
            gain_reg     <= '0;
            delay_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (spp_reg_t'(cfg_index))
                REG_SETPOINT:   setpoint_reg <= cfg_data;
                REG_KP:         kp_reg       <= cfg_data[30:0];
                REG_KI_DT:      ki_reg       <= cfg_data[30:0];
                REG_DECAY:      decay_reg    <= cfg_data[16:0];
                REG_INPUT_GAIN: gain_reg     <= cfg_data;
                REG_DELAY:      delay_reg    <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MDEC;
            ST_MDEC:  state_next = ST_MGAIN;
            ST_MGAIN: state_next = ST_MODEL;
            ST_MODEL: state_next = ST_FB;
            ST_FB:    state_next = ST_ERR;
            ST_ERR:   state_next = ST_KI;
            ST_KI:    state_next = ST_INT;
            ST_INT:   state_next = ST_DRV;
            ST_DRV:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operand pick and load strobes
    always_comb begin
        op_sel         = OP_DECAY;
        hist_ctl.write = 1'b0;
        ld_acc         = 1'b0;
        ld_model       = 1'b0;
        ld_fb          = 1'b0;
        ld_err         = 1'b0;
        ld_int         = 1'b0;
        ld_out         = 1'b0;
        unique case (state_reg)
            ST_IDLE:  op_sel = OP_DECAY;
            ST_MDEC:  op_sel = OP_DECAY;
            ST_MGAIN: begin
                op_sel = OP_GAIN;
                ld_acc = 1'b1;
            end
            ST_MODEL: begin
                ld_model       = 1'b1;
                hist_ctl.write = 1'b1;
            end
            ST_FB:    ld_fb = 1'b1;
            ST_ERR:   ld_err = 1'b1;
            ST_KI:    op_sel = OP_KI;
            ST_INT: begin
                op_sel = OP_KP;
                ld_int = 1'b1;
            end
            ST_DRV: begin
                // keep the kp product in the multiplier while waiting
                op_sel = OP_KP;
                ld_out = out_free;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (op_sel)
            OP_DECAY: begin
                mul_a = {15'd0, decay_reg};
                mul_b = ym_reg;
            end
            OP_GAIN: begin
                mul_a = gain_reg;
                mul_b = prev_reg;
            end
            OP_KI: begin
                mul_a = {1'b0, ki_reg};
                mul_b = err_reg;
            end
            OP_KP: begin
                mul_a = {1'b0, kp_reg};
                mul_b = err_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    spp_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk (aclk),
        .a_i  (mul_a),
        .b_i  (mul_b),
        .q_o  (mul_q)
    );

    spp_hist #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_i     (hist_ctl),
        .wdata_i   (model_sat.value),
        .delay_i   (delay_reg),
        .delayed_o (delayed)
    );

    // saturating sums, one used per step
    assign model_sat = sat32(acc_reg + mul_q);
    assign fb_sat    = sat32(ACC_W'(meas_reg) - ACC_W'(delayed) + ACC_W'(ym_reg));
    assign err_sat   = sat32(ACC_W'(setpoint_reg) - ACC_W'(fb_reg));
    assign int_sat   = sat32(ACC_W'(integ_reg) + mul_q);
    assign drv_sat   = sat32(mul_q + ACC_W'(integ_reg));

    // controller state that persists across ticks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ym_reg    <= '0;
            integ_reg <= '0;
            prev_reg  <= '0;
        end else begin
            if (ld_model) ym_reg <= model_sat.value;
            if (ld_int)   integ_reg <= int_sat.value;
            if (ld_out)   prev_reg <= drv_sat.value;
        end
    end

    // per-item working values
    always_ff @(posedge aclk) begin
        if (accept) meas_reg <= s_measured;
        // model update starts from ym minus the decay product
        if (ld_acc) acc_reg <= ACC_W'(ym_reg) - mul_q;
        if (ld_fb)  fb_reg <= fb_sat.value;
        if (ld_err) err_reg <= err_sat.value;
    end

    // clip flag collects over the whole tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else if (accept) begin
            flag_reg <= 1'b0;
        end else begin
            if (ld_model) flag_reg <= flag_reg | model_sat.clip;
            if (ld_fb)    flag_reg <= flag_reg | fb_sat.clip;
            if (ld_err)   flag_reg <= flag_reg | err_sat.clip;
            if (ld_int)   flag_reg <= flag_reg | int_sat.clip;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_drive_reg <= drv_sat.value;
            m_fb_reg    <= fb_reg;
            m_sat_reg   <= flag_reg | drv_sat.clip;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_drive              = m_drive_reg;
    assign m_predicted_feedback = m_fb_reg;
    assign m_saturated          = m_sat_reg;

endmodule

`default_nettype wire

@@ rtl/core/spp_mul.sv @@
// shared signed 32x32 multiplier with round half up to the fraction point, one register stage
// uses spp_pkg
`default_nettype none

module spp_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic signed [31:0]               a_i,
    input  logic signed [31:0]               b_i,
    output logic signed [spp_pkg::ACC_W-1:0] q_o
);
    import spp_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [ACC_W-1:0] full;
    logic signed [ACC_W-1:0] q_reg;

    assign full = ACC_W'(a_i) * ACC_W'(b_i);

    always_ff @(posedge aclk) begin
        q_reg <= (full + ROUND) >>> FRAC_BITS;
    end

    assign q_o = q_reg;

endmodule

`default_nettype wire

@@ rtl/core/spp_hist.sv @@
// model output history ring buffer with clamped read delay and fill tracking
// uses spp_pkg
`default_nettype none

module spp_hist #(
    parameter int DELAY_DEPTH = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  spp_pkg::spp_hist_ctl_t ctl_i,
    input  logic signed [31:0]     wdata_i,
    input  logic [7:0]             delay_i,
    output logic signed [31:0]     delayed_o
);
    import spp_pkg::*;

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [CW-1:0] DMAX  = CW'(DELAY_DEPTH - 1);
    localparam logic [CW-1:0] DFULL = CW'(DELAY_DEPTH);
    localparam logic [AW-1:0] PLAST = AW'(DELAY_DEPTH - 1);

    logic signed [31:0] mem [DELAY_DEPTH];

    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      ptr_next;
    logic               wrapped_reg;
    logic               wrapped_next;
    logic signed [31:0] q_reg;
    logic signed [31:0] self_reg;
    logic               sel_self_reg;
    logic               sel_blank_reg;

    logic [CW-1:0] d_ext;
    logic [CW-1:0] ptr_ext;
    logic [CW-1:0] diff;
    logic [AW-1:0] rd_addr;
    logic          zero_delay;
    logic          blank;

    // clamp delay, then step back modulo depth
    always_comb begin
        d_ext   = (CW'(delay_i) > DMAX) ? DMAX : CW'(delay_i);
        ptr_ext = CW'(ptr_reg);
        if (ptr_ext < d_ext) begin
            diff = ptr_ext + DFULL - d_ext;
        end else begin
            diff = ptr_ext - d_ext;
        end
        rd_addr    = diff[AW-1:0];
        zero_delay = (d_ext == '0);
        // entries above the pointer are unwritten until the first wrap
        blank      = !wrapped_reg && (rd_addr > ptr_reg);
    end

    always_comb begin
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        if (ctl_i.write) begin
            if (ptr_reg == PLAST) begin
                ptr_next     = '0;
                wrapped_next = 1'b1;
            end else begin
                ptr_next = ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.write) begin
            mem[ptr_reg] <= wdata_i;
            q_reg        <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            wrapped_reg   <= 1'b0;
            sel_self_reg  <= 1'b0;
            sel_blank_reg <= 1'b1;
        end else begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
            if (ctl_i.write) begin
                sel_self_reg  <= zero_delay;
                sel_blank_reg <= blank;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.write) begin
            self_reg <= wdata_i;
        end
    end

    always_comb begin
        priority if (sel_self_reg) begin
            delayed_o = self_reg;
        end else if (sel_blank_reg) begin
            delayed_o = '0;
        end else begin
            delayed_o = q_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/spp_checker.sv @@
// port-level assertions for the smith predictor pi controller, bound to the top level
// depends on smith_predictor_pi_controller ports only
`default_nettype none

module spp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_drive
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive))
        else $error("result changed while stalled");

    // after an accepted item, s_ready must stay low in the MDEC, MGAIN and MODEL steps
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("input ready too soon after an item");

    // a new result appears only out of a busy sequencer
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work in progress");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind smith_predictor_pi_controller spp_checker u_spp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_drive (m_drive)
);

`default_nettype wire
